// ----- rtl/feedback_delay_echo_core_macros.svh -----
// assertion macros for the feedback delay echo core
`ifndef FEEDBACK_DELAY_ECHO_CORE_MACROS_SVH
`define FEEDBACK_DELAY_ECHO_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fde_pkg.sv -----
// constants, types and helper functions of the feedback delay echo core
`timescale 1ns / 1ps
`default_nettype none

package fde_pkg;

    localparam int RING_DEPTH   = 65536;
    localparam int MAX_CHANNELS = 2;
    localparam int SAMPLE_BITS  = 16;

    localparam int WP_BITS   = $clog2(RING_DEPTH);
    localparam int CH_BITS   = $clog2(MAX_CHANNELS);
    localparam int ADDR_BITS = WP_BITS + CH_BITS;
    localparam int MEM_DEPTH = RING_DEPTH * MAX_CHANNELS;

    localparam int DELAY_BITS     = 17;
    localparam int GAIN_BITS      = 7;
    localparam int CHAN_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    // x / 100 for x below 2^22 is (x * ceil(2^29 / 100)) >> 29
    localparam int PERCENT_SCALE = 100;
    localparam int DIV_SHIFT     = 29;
    localparam int DIV_RECIP     = (2 ** DIV_SHIFT + PERCENT_SCALE - 1) / PERCENT_SCALE;
    localparam int COEF_BITS     = 30;

    localparam int MAG_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS = MAG_BITS + COEF_BITS;
    localparam int QUOT_BITS = PROD_BITS - DIV_SHIFT;
    localparam int SUM_BITS  = QUOT_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CFG_INDEX_BITS-1:0]     t_cfg_index;
    typedef logic [COEF_BITS-1:0]          t_coef;

    localparam t_sample SAMPLE_MAX = t_sample'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam t_sample SAMPLE_MIN = t_sample'(-(2 ** (SAMPLE_BITS - 1)));

    localparam t_cfg_index REG_DELAY    = t_cfg_index'(0);
    localparam t_cfg_index REG_LEVEL    = t_cfg_index'(1);
    localparam t_cfg_index REG_FEEDBACK = t_cfg_index'(2);
    localparam t_cfg_index REG_CHANNELS = t_cfg_index'(3);
    localparam t_cfg_index REG_BYPASS   = t_cfg_index'(4);

    localparam logic [DELAY_BITS-1:0] DELAY_RESET    = DELAY_BITS'(50000);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET     = GAIN_BITS'(50);
    localparam logic [CHAN_BITS-1:0]  CHANNELS_RESET = CHAN_BITS'(1);

    function automatic logic [GAIN_BITS-1:0] clamp_gain(input logic [GAIN_BITS-1:0] g);
        logic [GAIN_BITS-1:0] lim;
        lim = GAIN_BITS'(PERCENT_SCALE);
        return (g > lim) ? lim : g;
    endfunction

    // gain percent folded with the reciprocal of 100
    function automatic t_coef gain_coef(input logic [GAIN_BITS-1:0] g);
        return t_coef'(COEF_BITS'(clamp_gain(g)) * COEF_BITS'(DIV_RECIP));
    endfunction

    function automatic t_sample saturate(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'(SAMPLE_MAX);
        lo = SUM_BITS'(SAMPLE_MIN);
        if (v > hi) begin
            return SAMPLE_MAX;
        end else if (v < lo) begin
            return SAMPLE_MIN;
        end
        return t_sample'(v[SAMPLE_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fde_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/feedback_delay_echo_core.sv -----
// Feedback delay echo core for an interleaved audio sample stream.
//
// Input channel: i_in_valid / o_in_stall carry one signed sample per request;
// the core tracks the interleaved channel itself. Output channel:
// o_out_valid / i_out_stall carry one processed sample per input request.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// it is always ready. Registers: 0 delay, 1 level, 2 feedback, 3 channel
// count, 4 bypass; other indexes are ignored. Write only while idle.
// A sample accepted into the processing stage moves on to the result register,
// which drives o_sample_out, once that register can advance. The core takes one
// sample per cycle while o_in_stall is low, set by the single delay ram read and
// write per sample and the feedback path (multiply, add, saturate) that forwards
// the last stored sample to the next read. Reset (i_rst_n low, synchronous)
// restores the register defaults and then clears all 131072 delay ram entries
// one per cycle while o_in_stall stays high. Config writes are still taken during
// that pass. When the receiver stalls, the result register holds and one more
// sample enters the processing stage, if empty, before o_in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

`include "feedback_delay_echo_core_macros.svh"

module feedback_delay_echo_core
    import fde_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // sample input
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // sample output
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]  o_sample_out,
    // config write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // config registers
    logic [DELAY_BITS-1:0] r_delay;
    logic [GAIN_BITS-1:0]  r_level;
    logic [GAIN_BITS-1:0]  r_feedback;
    logic [CHAN_BITS-1:0]  r_chan_count;
    logic                  r_bypass;
    t_coef                 r_lv_coef;
    t_coef                 r_fb_coef;

    // position counters
    logic [WP_BITS-1:0]    r_wp;
    logic [CH_BITS-1:0]    r_cc;

    // ram clearing pass
    logic                  r_clr_busy;
    logic [ADDR_BITS-1:0]  r_clr_addr;

    // processing stage
    logic                  r_v1;
    t_sample               r_s1_dry;
    logic [CH_BITS-1:0]    r_s1_bank;
    logic [WP_BITS-1:0]    r_s1_wp;
    logic                  r_s1_fwd;
    t_sample               r_wr_data;

    // result register
    logic                  r_ov;
    t_sample               r_out;

    logic                  cfg_we;
    logic                  in_acc;
    logic                  adv;
    logic                  stage_we;
    logic [DELAY_BITS-1:0] delay_c;
    logic [CHAN_BITS-1:0]  chans_c;
    logic                  cc_last;
    logic [CH_BITS-1:0]    bank;
    logic [WP_BITS-1:0]    rd_pos;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  s1_addr;
    logic                  fwd_hit;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic                  ram_we;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    t_sample                    delayed;
    logic signed [MAG_BITS-1:0] d_ext;
    logic                       d_neg;
    logic [MAG_BITS-1:0]        d_mag;
    logic [PROD_BITS-1:0]       fb_prod;
    logic [PROD_BITS-1:0]       lv_prod;
    logic signed [SUM_BITS-1:0] fb_term;
    logic signed [SUM_BITS-1:0] lv_term;
    logic signed [SUM_BITS-1:0] dry_ext;
    t_sample                    stored;
    t_sample                    result;

    // ---------------------------------------------------------------- config

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= DELAY_RESET;
            r_level      <= GAIN_RESET;
            r_feedback   <= GAIN_RESET;
            r_chan_count <= CHANNELS_RESET;
            r_bypass     <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_DELAY:    r_delay      <= i_cfg_data[DELAY_BITS-1:0];
                REG_LEVEL:    r_level      <= i_cfg_data[GAIN_BITS-1:0];
                REG_FEEDBACK: r_feedback   <= i_cfg_data[GAIN_BITS-1:0];
                REG_CHANNELS: r_chan_count <= i_cfg_data[CHAN_BITS-1:0];
                REG_BYPASS:   r_bypass     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // coefficients are registered from the level and feedback registers
    always_ff @(posedge i_clk) begin
        r_lv_coef <= gain_coef(r_level);
        r_fb_coef <= gain_coef(r_feedback);
    end

    // ---------------------------------------------------------------- handshake

    assign adv        = !r_ov || !i_out_stall;
    assign o_in_stall = r_clr_busy || (r_v1 && !adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign stage_we   = r_v1 && adv && !r_bypass;

    // ---------------------------------------------------------------- addressing

    always_comb begin
        delay_c = r_delay;
        if (r_delay == '0) begin
            delay_c = DELAY_BITS'(1);
        end else if (r_delay > DELAY_BITS'(RING_DEPTH)) begin
            delay_c = DELAY_BITS'(RING_DEPTH);
        end
    end

    always_comb begin
        chans_c = r_chan_count;
        if (r_chan_count == '0) begin
            chans_c = CHAN_BITS'(1);
        end else if (r_chan_count > CHAN_BITS'(MAX_CHANNELS)) begin
            chans_c = CHAN_BITS'(MAX_CHANNELS);
        end
    end

    assign cc_last = (CHAN_BITS'(r_cc) + CHAN_BITS'(1)) >= chans_c;
    assign bank    = (int'(r_cc) < MAX_CHANNELS) ? r_cc : '0;
    // ring depth is a power of two, so the wrap is a truncation
    assign rd_pos  = WP_BITS'(DELAY_BITS'(r_wp) - delay_c);
    assign rd_addr = {bank, rd_pos};
    assign s1_addr = {r_s1_bank, r_s1_wp};

    // the sample in the stage is written at the same edge the new read happens
    assign fwd_hit = r_v1 && !r_bypass && (rd_addr == s1_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_cc <= '0;
        end else if (in_acc && !r_bypass) begin
            if (cc_last) begin
                r_cc <= '0;
                r_wp <= r_wp + WP_BITS'(1);
            end else begin
                r_cc <= r_cc + CH_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            if (r_clr_addr == ADDR_BITS'(MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- delay ram

    assign ram_we    = r_clr_busy || stage_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : SAMPLE_BITS'(stored);

    fde_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- processing stage

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (in_acc) begin
            r_v1 <= 1'b1;
        end else if (adv) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_dry  <= i_sample_in;
            r_s1_bank <= bank;
            r_s1_wp   <= r_wp;
            r_s1_fwd  <= fwd_hit;
        end
        if (stage_we) begin
            r_wr_data <= stored;
        end
    end

    always_comb begin
        delayed = r_s1_fwd ? r_wr_data : t_sample'(ram_rdata);
        d_ext   = MAG_BITS'(delayed);
        d_neg   = delayed[SAMPLE_BITS-1];
        d_mag   = d_neg ? MAG_BITS'(-d_ext) : MAG_BITS'(d_ext);

        // magnitude times gain / 100, truncated, then the sign put back
        fb_prod = PROD_BITS'(d_mag) * PROD_BITS'(r_fb_coef);
        lv_prod = PROD_BITS'(d_mag) * PROD_BITS'(r_lv_coef);
        fb_term = SUM_BITS'(fb_prod[PROD_BITS-1:DIV_SHIFT]);
        lv_term = SUM_BITS'(lv_prod[PROD_BITS-1:DIV_SHIFT]);
        if (d_neg) begin
            fb_term = -fb_term;
            lv_term = -lv_term;
        end

        dry_ext = SUM_BITS'(r_s1_dry);
        stored  = saturate(dry_ext + fb_term);
        result  = r_bypass ? r_s1_dry : saturate(dry_ext + lv_term);
    end

    // ---------------------------------------------------------------- result register

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v1) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;

    // ---------------------------------------------------------------- assertions

    `FDE_ASSERT_NOW(a_clear_empty, i_clk, i_rst_n, r_clr_busy, !r_v1 && !r_ov,
                    "request in flight during ram clear")
    `FDE_ASSERT_NOW(a_fwd_has_write, i_clk, i_rst_n, in_acc && fwd_hit,
                    stage_we && !r_clr_busy, "forward without a matching write")
    `FDE_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_v1 && r_ov && i_out_stall,
                     r_v1 && $stable(r_s1_dry) && $stable(r_s1_wp),
                     "stalled stage lost its request")
    `FDE_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, in_acc && !r_bypass && cc_last,
                     r_cc == '0, "channel counter did not wrap")

endmodule

`default_nettype wire
